[rtl/mcs_pkg.sv]
// shared types and constants for the markov chain sampler
package mcs_pkg;
  localparam int NUM_STATES   = 64;
  localparam int NUM_MATRICES = 16;
  localparam int STATE_W      = $clog2(NUM_STATES);
  localparam int MATRIX_W     = $clog2(NUM_MATRICES);
  localparam int ADDR_W       = MATRIX_W + 2 * STATE_W;
  localparam int CDF_W        = 33;
  localparam int UNI_W        = 32;
  localparam int GUIDE_W      = 2 * STATE_W;
  localparam int SEARCH_STEPS = STATE_W + 1;
  localparam int STEP_W       = $clog2(SEARCH_STEPS + 1);
  localparam int QUEUE_DEPTH  = 2;

  localparam logic [1:0] OP_SAMPLE = 2'd0;
  localparam logic [1:0] OP_GUIDE  = 2'd1;
  localparam logic [1:0] OP_CDF    = 2'd2;

  // command handed from the front part to the back part
  typedef struct packed {
    logic [1:0]          opcode;
    logic [MATRIX_W-1:0] matrix_index;
    logic [STATE_W-1:0]  from_state;
    logic [STATE_W-1:0]  column;
    logic [GUIDE_W-1:0]  guide;
    logic [CDF_W-1:0]    cdf_value;
    logic [UNI_W-1:0]    uniform_bits;
  } mcs_cmd_t;

  function automatic logic [ADDR_W-1:0] mcs_addr(logic [MATRIX_W-1:0] m,
                                                 logic [STATE_W-1:0] c,
                                                 logic [STATE_W-1:0] r);
    mcs_addr = {m, c, r};
  endfunction
endpackage

[rtl/mcs_front.sv]
// front part: accepts items, drops unused opcodes, queues commands
module mcs_front import mcs_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  mcs_cmd_t            in_cmd,
  output logic                q_valid,
  input  logic                q_pop,
  output mcs_cmd_t            q_cmd
);
  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  mcs_cmd_t           mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [PTR_W:0]     count;
  logic               push;
  logic               take;

  assign in_stall = (count == (PTR_W+1)'(QUEUE_DEPTH));
  assign take     = in_valid && !in_stall;
  // unused opcode is consumed without entering the queue
  assign push     = take && (in_cmd.opcode inside {OP_SAMPLE, OP_GUIDE, OP_CDF});
  assign q_valid  = (count != '0);
  assign q_cmd    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= in_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (q_pop && q_valid) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (PTR_W+1)'(push) - (PTR_W+1)'(q_pop && q_valid);
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    count <= (PTR_W+1)'(QUEUE_DEPTH)) else $error("queue overflow");
  assert property (@(posedge clk) disable iff (rst)
    (!q_valid) |-> !q_pop || !q_valid) else $error("pop from empty queue");
  assert property (@(posedge clk) disable iff (rst)
    (push && !(q_pop && q_valid)) |=> count == $past(count) + 1'b1)
    else $error("push lost");
endmodule

[rtl/mcs_back.sv]
// back part: table writes and guided binary search over the cdf memory
module mcs_back import mcs_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  output logic               q_pop,
  input  mcs_cmd_t           q_cmd,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [STATE_W-1:0] next_state
);
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_GUIDE = 3'd1;
  localparam logic [2:0] S_CDF0  = 3'd2;
  localparam logic [2:0] S_CHECK = 3'd3;
  localparam logic [2:0] S_MID   = 3'd4;
  localparam logic [2:0] S_STEP  = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [GUIDE_W-1:0] guide_mem [2**ADDR_W];
  logic [CDF_W-1:0]   cdf_mem   [2**ADDR_W];
  logic [GUIDE_W-1:0] guide_rd;
  logic [CDF_W-1:0]   cdf_rd;

  logic [2:0]          state;
  mcs_cmd_t            cmd;
  logic [STATE_W-1:0]  ub;
  logic [STATE_W-1:0]  lb;
  logic [STATE_W-1:0]  mid;
  logic [STEP_W-1:0]   steps;
  logic [ADDR_W-1:0]   guide_addr;
  logic [ADDR_W-1:0]   cdf_addr;
  logic [STATE_W-1:0]  bucket;
  logic [STATE_W-1:0]  mid_calc;
  logic                u_below;
  logic                wide_gap;

  assign bucket   = cmd.uniform_bits[UNI_W-1 -: STATE_W];
  assign mid_calc = STATE_W'(({1'b0, ub} + {1'b0, lb}) >> 1);
  assign u_below  = {1'b0, cmd.uniform_bits} < cdf_rd;
  assign wide_gap = ({1'b0, ub} > {1'b0, lb} + (STATE_W+1)'(1));
  assign q_pop    = (state == S_IDLE) && q_valid;

  always_comb begin
    guide_addr = mcs_addr(cmd.matrix_index, bucket, cmd.from_state);
    cdf_addr   = mcs_addr(cmd.matrix_index, (state == S_GUIDE) ? '0 : mid, cmd.from_state);
  end

  // single-port style memories with registered read
  always_ff @(posedge clk) begin
    if (q_pop && q_cmd.opcode == OP_GUIDE)
      guide_mem[mcs_addr(q_cmd.matrix_index, q_cmd.column, q_cmd.from_state)] <= q_cmd.guide;
    guide_rd <= guide_mem[guide_addr];
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_cmd.opcode == OP_CDF)
      cdf_mem[mcs_addr(q_cmd.matrix_index, q_cmd.column, q_cmd.from_state)] <= q_cmd.cdf_value;
    cdf_rd <= cdf_mem[cdf_addr];
  end

  always_ff @(posedge clk) begin
    if (q_pop) cmd <= q_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (q_valid && q_cmd.opcode == OP_SAMPLE) state <= S_GUIDE;
        end
        S_GUIDE: state <= S_CDF0;          // guide and cdf[0] reads in flight
        S_CDF0: begin
          ub    <= guide_rd[GUIDE_W-1 -: STATE_W];
          lb    <= guide_rd[STATE_W-1:0];
          steps <= '0;
          if (guide_rd[STATE_W-1:0] == '0 && {1'b0, cmd.uniform_bits} < cdf_rd)
            ub <= '0;
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (wide_gap && steps != STEP_W'(SEARCH_STEPS)) begin
            mid   <= mid_calc;
            state <= S_MID;
          end else begin
            next_state <= ub;
            out_valid  <= 1'b1;
            state      <= S_OUT;
          end
        end
        S_MID: state <= S_STEP;            // cdf[mid] read in flight
        S_STEP: begin
          if (u_below) ub <= mid;
          else lb <= mid;
          steps <= steps + 1'b1;
          state <= S_CHECK;
        end
        S_OUT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> state == S_OUT) else $error("result outside output state");
  assert property (@(posedge clk) disable iff (rst)
    (state == S_STEP) |=> steps <= STEP_W'(SEARCH_STEPS)) else $error("search overrun");
  assert property (@(posedge clk) disable iff (rst)
    q_pop |-> state == S_IDLE) else $error("pop while busy");
endmodule

[rtl/markov_chain_inverse_cdf_sampler.sv]
// top level of the markov chain inverse-cdf sampler
//
// input channel: in_valid / in_stall with one port per field; opcode 0
// samples a next state, opcode 1 writes a guide bracket, opcode 2 writes a
// cdf entry, opcode 3 is consumed and ignored. only a sample yields a result.
// output channel: out_valid / out_stall carrying next_state; one transfer
// per sample, in input order.
// a front part takes items into a two-entry command queue, so input
// transfers continue while the back part searches or its result waits.
// a transfer enters the queue in the cycle before the back part can first pop it.
// a write is done as the back part pops it, while it stays idle. a sample reads
// its guide bracket and cdf[0], makes the first bracket check, then runs binary
// search steps, each step waiting on its own cdf read; the search ends once the
// bracket narrows to one state, after at most 6 steps at 64 states, and the
// result is then handed on.
// reset (synchronous, rst high) empties the queue and idles the back part;
// table contents are not cleared and must be written before use.
// while out_stall is high the result holds and the back part waits; the
// queue then fills and raises in_stall.
module markov_chain_inverse_cdf_sampler import mcs_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          opcode,
  input  logic [MATRIX_W-1:0] matrix_index,
  input  logic [STATE_W-1:0]  from_state,
  input  logic [STATE_W-1:0]  column,
  input  logic [STATE_W-1:0]  guide_upper,
  input  logic [STATE_W-1:0]  guide_lower,
  input  logic [CDF_W-1:0]    cdf_value,
  input  logic [UNI_W-1:0]    uniform_bits,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [STATE_W-1:0]  next_state
);
  mcs_cmd_t in_cmd;
  mcs_cmd_t q_cmd;
  logic     q_valid;
  logic     q_pop;

  // pack the input fields into one command
  assign in_cmd = '{opcode: opcode, matrix_index: matrix_index, from_state: from_state,
                    column: column, guide: {guide_upper, guide_lower},
                    cdf_value: cdf_value, uniform_bits: uniform_bits};

  mcs_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .in_cmd(in_cmd), .q_valid(q_valid), .q_pop(q_pop), .q_cmd(q_cmd)
  );

  mcs_back u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_pop(q_pop), .q_cmd(q_cmd),
    .out_valid(out_valid), .out_stall(out_stall), .next_state(next_state)
  );
endmodule

[verif/testbench.sv]
// self-checking testbench for the markov chain inverse-cdf sampler
module testbench;
  import mcs_pkg::*;

  // one input transfer as the driver offers it
  typedef struct {
    logic [1:0]          op;
    logic [MATRIX_W-1:0] mat;
    logic [STATE_W-1:0]  row;
    logic [STATE_W-1:0]  col;
    logic [STATE_W-1:0]  up;
    logic [STATE_W-1:0]  lo;
    logic [CDF_W-1:0]    cdf;
    logic [UNI_W-1:0]    uni;
  } mcs_item_t;

  localparam int CYCLE_LIMIT = 1000000;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [1:0]          opcode = OP_SAMPLE;
  logic [MATRIX_W-1:0] matrix_index = '0;
  logic [STATE_W-1:0]  from_state = '0;
  logic [STATE_W-1:0]  column = '0;
  logic [STATE_W-1:0]  guide_upper = '0;
  logic [STATE_W-1:0]  guide_lower = '0;
  logic [CDF_W-1:0]    cdf_value = '0;
  logic [UNI_W-1:0]    uniform_bits = '0;
  logic                out_valid;
  logic                out_stall = 1'b1;
  logic [STATE_W-1:0]  next_state;

  // predictor copies of the two tables
  logic [GUIDE_W-1:0]  guide_mem [int];
  logic [CDF_W-1:0]    cdf_mem [int];

  mcs_item_t           pending_items[$];
  mcs_item_t           last_offered;
  logic [STATE_W-1:0]  expected_states[$];
  int                  mismatches = 0;
  int                  samples_checked = 0;
  int                  writes_sent = 0;
  int                  cycles = 0;
  int                  gap_left = 0;
  int                  stall_left = 0;
  bit                  stimulus_done = 1'b0;
  bit                  sender_hold = 1'b0;
  bit                  long_hold_req = 1'b0;

  always #1 clk = ~clk;

  markov_chain_inverse_cdf_sampler u_dut (.*);

  // predicted next state for one sample, from the predictor tables
  function automatic logic [STATE_W-1:0] predict_next(mcs_item_t it);
    int bucket, ub, lb, mid;
    logic [GUIDE_W-1:0] g;
    bucket = int'(it.uni[UNI_W-1 -: STATE_W]);
    g  = guide_mem[int'(mcs_addr(it.mat, STATE_W'(bucket), it.row))];
    ub = int'(g[GUIDE_W-1 -: STATE_W]);
    lb = int'(g[STATE_W-1:0]);
    if (lb == 0 && {1'b0, it.uni} < cdf_mem[int'(mcs_addr(it.mat, '0, it.row))])
      ub = 0;
    if (ub - lb > 1) begin
      for (int i = 0; i < SEARCH_STEPS; i++) begin
        mid = (ub + lb) / 2;
        if ({1'b0, it.uni} < cdf_mem[int'(mcs_addr(it.mat, STATE_W'(mid), it.row))])
          ub = mid;
        else
          lb = mid;
        if (ub - lb <= 1)
          break;
      end
    end
    return ub[STATE_W-1:0];
  endfunction

  // queue helpers; the predictor tables follow the writes as they transfer
  task automatic push_guide(int m, int row, int bucket, int up, int lo);
    mcs_item_t it;
    it = '{OP_GUIDE, MATRIX_W'(m), STATE_W'(row), STATE_W'(bucket), STATE_W'(up),
           STATE_W'(lo), CDF_W'($urandom), UNI_W'($urandom)};
    it.cdf[CDF_W-1] = 1'($urandom_range(0, 1));
    pending_items.push_back(it);
  endtask

  task automatic push_cdf(int m, int row, int target, logic [CDF_W-1:0] v);
    mcs_item_t it;
    it = '{OP_CDF, MATRIX_W'(m), STATE_W'(row), STATE_W'(target), STATE_W'($urandom),
           STATE_W'($urandom), v, UNI_W'($urandom)};
    pending_items.push_back(it);
  endtask

  task automatic push_sample(int m, int row, logic [UNI_W-1:0] u);
    mcs_item_t it;
    it = '{OP_SAMPLE, MATRIX_W'(m), STATE_W'(row), STATE_W'($urandom), STATE_W'($urandom),
           STATE_W'($urandom), CDF_W'($urandom), u};
    it.cdf[CDF_W-1] = 1'($urandom_range(0, 1));
    pending_items.push_back(it);
  endtask

  // fill a whole well-formed row: sorted cdf and matching guide brackets
  task automatic load_row(int m, int row, bit saturate);
    logic [CDF_W-1:0] c [$];
    int lo_s, hi_s;
    logic [CDF_W-1:0] edge_lo, edge_hi;
    for (int t = 0; t < NUM_STATES; t++)
      c.push_back({1'b0, $urandom});
    c.sort();
    if (saturate) c[NUM_STATES-1] = 33'h1_0000_0000;
    for (int t = 0; t < NUM_STATES; t++) push_cdf(m, row, t, c[t]);
    for (int b = 0; b < NUM_STATES; b++) begin
      edge_lo = 33'(b) << 26;
      edge_hi = (33'(b + 1) << 26) - 1;
      lo_s = 0;
      for (int t = 0; t < NUM_STATES; t++)
        if (c[t] <= edge_lo) lo_s = t;
      hi_s = NUM_STATES - 1;
      for (int t = NUM_STATES - 1; t >= 0; t--)
        if (c[t] > edge_hi) hi_s = t;
      if (hi_s < lo_s) hi_s = lo_s;
      push_guide(m, row, b, hi_s, lo_s);
    end
  endtask

  // a row whose guide entries are arbitrary, inverted brackets included
  task automatic load_odd_row(int m, int row);
    for (int t = 0; t < NUM_STATES; t++)
      push_cdf(m, row, t, {1'($urandom_range(0, 1)), $urandom});
    for (int b = 0; b < NUM_STATES; b++)
      push_guide(m, row, b, $urandom_range(0, 63), $urandom_range(0, 63));
  endtask

  task automatic wait_drained();
    while (pending_items.size() != 0 || expected_states.size() != 0 || in_valid)
      @(posedge clk);
  endtask

  // stimulus
  initial begin
    int loaded_m [$];
    int loaded_r [$];
    int k, m, r;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed part: extremes of row and matrix, saturated last cdf
    load_row(0, 0, 1'b1);
    load_row(15, 63, 1'b1);
    load_odd_row(7, 42);
    loaded_m = '{0, 15, 7};
    loaded_r = '{0, 63, 42};
    push_sample(0, 0, 32'h0000_0000);
    push_sample(0, 0, 32'hFFFF_FFFF);
    push_sample(15, 63, 32'h0000_0000);
    push_sample(15, 63, 32'hFFFF_FFFF);
    push_sample(15, 63, 32'h8000_0000);
    push_sample(7, 42, 32'h0400_0000);
    push_sample(7, 42, 32'hFC00_0001);
    pending_items.push_back('{OP_UNUSED, '1, '1, '1, '1, '1, '1, '1});
    pending_items.push_back('{OP_UNUSED, '0, '0, '0, '0, '0, '0, '0});
    // writes at both ends of the cdf range, then sample through them
    push_cdf(0, 0, 0, 33'h1_0000_0000);
    push_sample(0, 0, 32'hFFFF_FFFF);
    push_cdf(0, 0, 0, 33'h0);
    push_sample(0, 0, 32'h0);
    wait_drained();

    // sender pause until every expected result has come, then a long receiver hold
    sender_hold = 1'b1;
    wait_drained();
    sender_hold = 1'b0;
    long_hold_req = 1'b1;
    for (int i = 0; i < 20; i++) push_sample(15, 63, $urandom);

    // random part: mostly samples on loaded rows, some new rows and noise
    for (int i = 0; i < 430; i++) begin
      k = $urandom_range(0, 99);
      if (k < 2 && loaded_m.size() < 5) begin
        m = $urandom_range(0, 15);
        r = $urandom_range(0, 63);
        if (k == 0) load_odd_row(m, r); else load_row(m, r, 1'($urandom_range(0, 1)));
        loaded_m.push_back(m);
        loaded_r.push_back(r);
      end else if (k < 5) begin
        pending_items.push_back('{OP_UNUSED, MATRIX_W'($urandom), STATE_W'($urandom),
                                  STATE_W'($urandom), STATE_W'($urandom), STATE_W'($urandom),
                                  CDF_W'({$urandom, $urandom}), UNI_W'($urandom)});
      end else begin
        k = $urandom_range(0, loaded_m.size() - 1);
        push_sample(loaded_m[k], loaded_r[k], $urandom);
      end
    end
    stimulus_done = 1'b1;
  end

  // driver: hold the payload while stalled, random gaps between transfers
  always @(posedge clk) begin
    mcs_item_t it;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        if (it_op_is_sample(opcode)) begin
          expected_states.push_back(predict_next(last_offered));
        end else begin
          writes_sent <= writes_sent + 1;
          if (opcode == OP_GUIDE)
            guide_mem[int'(mcs_addr(last_offered.mat, last_offered.col, last_offered.row))] =
              {last_offered.up, last_offered.lo};
          else if (opcode == OP_CDF)
            cdf_mem[int'(mcs_addr(last_offered.mat, last_offered.col, last_offered.row))] =
              last_offered.cdf;
        end
      end
      if (in_valid && in_stall) begin
        // keep offering the same item
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (!sender_hold && pending_items.size() != 0) begin
        it = pending_items.pop_front();
        last_offered <= it;
        in_valid     <= 1'b1;
        opcode       <= it.op;
        matrix_index <= it.mat;
        from_state   <= it.row;
        column       <= it.col;
        guide_upper  <= it.up;
        guide_lower  <= it.lo;
        cdf_value    <= it.cdf;
        uniform_bits <= it.uni;
        gap_left     <= pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  function automatic bit it_op_is_sample(logic [1:0] op);
    return op == OP_SAMPLE;
  endfunction

  // mostly no gap, sometimes short, rarely long
  function automatic int pick_gap();
    int k;
    k = $urandom_range(0, 99);
    if (k < 55) return 0;
    if (k < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // monitor: random stall on the result side, checks against the oldest prediction
  always @(posedge clk) begin
    logic [STATE_W-1:0] want;
    cycles <= cycles + 1;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_states.size() == 0) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10)
            $display("unexpected result transfer: next_state=%0d", next_state);
        end else begin
          want = expected_states.pop_front();
          samples_checked <= samples_checked + 1;
          if (next_state !== want) begin
            mismatches = mismatches + 1;
            if (mismatches <= 10)
              $display("next_state mismatch: expected %0d actual %0d", want, next_state);
          end
        end
      end
      if (long_hold_req) begin
        long_hold_req <= 1'b0;
        stall_left <= 300;
        out_stall  <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall  <= 1'b1;
      end else begin
        out_stall  <= (pick_gap() != 0);
        if ($urandom_range(0, 99) < 3) stall_left <= $urandom_range(5, 30);
      end
    end
  end

  // end of run and watchdog
  initial begin
    wait (stimulus_done);
    while (pending_items.size() != 0 || expected_states.size() != 0 || in_valid)
      @(posedge clk);
    repeat (60) @(posedge clk);
    $display("checked %0d sampled next states, %0d table writes and unused opcodes",
             samples_checked, writes_sent);
    $display("covered saturated and zero cdf ends, inverted brackets, long result stalls");
    if (mismatches == 0 && expected_states.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Verification failed");
      $finish;
    end
  end
endmodule
